@@ hdl/ssp_pkg.sv @@
// ssp_pkg: widths, fixed-point constants, arctangent table and queue entry type
// shared by the self scattering phase accumulator modules; no dependencies
package ssp_pkg;

  localparam int DISP_W     = 32;
  localparam int WAVE_W     = 10;
  localparam int SUM_W      = 35;
  localparam int SCALE_W    = 32;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int PROD_W     = DISP_W + WAVE_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int MAG_W      = PROD_W;
  localparam int MAG_LO_W   = 32;
  localparam int MAG_HI_W   = MAG_W - MAG_LO_W;
  localparam int PPLO_W     = MAG_LO_W + SCALE_W;
  localparam int PPHI_W     = MAG_HI_W + SCALE_W;

  // remainder width (2 pi in Q.44); the quotient is estimated from the top product
  // bits times 2^76 / (2 pi in Q.44) and is low by at most one
  localparam int RES_W       = 47;
  localparam int PROD_TOT_W  = PPHI_W + MAG_LO_W;
  localparam int QTOP_LSB    = 44;
  localparam int QTOP_W      = PROD_TOT_W - QTOP_LSB;
  localparam int RECIP_W     = 30;
  localparam int RECIP_SHIFT = 32;
  localparam int QUOT_W      = QTOP_W + RECIP_W - RECIP_SHIFT;
  localparam int M_SPLIT     = 24;
  localparam int FRAC_DROP   = 14;

  localparam int ANG_W      = 34;
  localparam int TRIG_W     = 20;
  localparam int ATAN_IDX_W = 5;

  localparam int Q_DEPTH    = 8;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIES_A_COUNT = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RST = 32'd1686629713;
  localparam logic [COUNT_W-1:0] COUNT_RST = 13'd4096;

  localparam logic [RES_W-1:0]   TWO_PI_Q44   = 47'h6487ED5110B5;
  localparam logic [RECIP_W-1:0] RECIP_TWO_PI = 30'h28BE60DB;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sh0C90FDAA2;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 34'sh1921FB544;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sh06487ED51;
  localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sh026DD3B6A;

  localparam logic signed [SUM_W:0] SUM_MAX = 36'sh3FFFFFFFF;
  localparam logic signed [SUM_W:0] SUM_MIN = -36'sh400000000;

  typedef struct packed {
    logic [PPLO_W-1:0] pp_lo;
    logic [PPHI_W-1:0] pp_hi;
    logic              neg;
    logic              is_a;
    logic              last;
  } ssp_work_t;

  // atan(2^-i) in Q.30, truncated
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 34'sh03243F6A8;
      5'd1:    v = 34'sh01DAC6705;
      5'd2:    v = 34'sh00FADBAFC;
      5'd3:    v = 34'sh007F56EA6;
      5'd4:    v = 34'sh003FEAB76;
      5'd5:    v = 34'sh001FFD55B;
      5'd6:    v = 34'sh000FFFAAA;
      5'd7:    v = 34'sh0007FFF55;
      5'd8:    v = 34'sh0003FFFEA;
      5'd9:    v = 34'sh0001FFFFD;
      5'd10:   v = 34'sh0000FFFFF;
      5'd11:   v = 34'sh00007FFFF;
      5'd12:   v = 34'sh00003FFFF;
      5'd13:   v = 34'sh00001FFFF;
      5'd14:   v = 34'sh00000FFFF;
      5'd15:   v = 34'sh000007FFF;
      5'd16:   v = 34'sh000003FFF;
      5'd17:   v = 34'sh000001FFF;
      5'd18:   v = 34'sh000000FFF;
      5'd19:   v = 34'sh0000007FF;
      5'd20:   v = 34'sh0000003FF;
      5'd21:   v = 34'sh0000001FF;
      5'd22:   v = 34'sh0000000FF;
      5'd23:   v = 34'sh00000007F;
      5'd24:   v = 34'sh00000003F;
      5'd25:   v = 34'sh00000001F;
      5'd26:   v = 34'sh00000000F;
      5'd27:   v = 34'sh000000008;
      5'd28:   v = 34'sh000000004;
      5'd29:   v = 34'sh000000002;
      5'd30:   v = 34'sh000000001;
      default: v = 34'sh000000000;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/ssp_in_if.sv @@
// ssp_in_if: particle channel, valid/ready plus displacement and wave-vector fields
// depends on ssp_pkg
interface ssp_in_if import ssp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DISP_W-1:0] disp_x;
  logic signed [DISP_W-1:0] disp_y;
  logic signed [DISP_W-1:0] disp_z;
  logic signed [WAVE_W-1:0] wave_x;
  logic signed [WAVE_W-1:0] wave_y;
  logic signed [WAVE_W-1:0] wave_z;
  logic                     last_particle;

  modport source (
    output valid, disp_x, disp_y, disp_z, wave_x, wave_y, wave_z, last_particle,
    input  ready
  );
  modport sink (
    input  valid, disp_x, disp_y, disp_z, wave_x, wave_y, wave_z, last_particle,
    output ready
  );
endinterface

@@ hdl/ssp_out_if.sv @@
// ssp_out_if: result channel, valid/ready plus the four species sums
// depends on ssp_pkg
interface ssp_out_if import ssp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_re_a;
  logic signed [SUM_W-1:0] sum_im_a;
  logic signed [SUM_W-1:0] sum_re_b;
  logic signed [SUM_W-1:0] sum_im_b;

  modport source (
    output valid, sum_re_a, sum_im_a, sum_re_b, sum_im_b,
    input  ready
  );
  modport sink (
    input  valid, sum_re_a, sum_im_a, sum_re_b, sum_im_b,
    output ready
  );
endinterface

@@ hdl/ssp_front.sv @@
// ssp_front: accepts particles, tags species from the running index and forms
// |dot| * phase_scale as two partial products; depends on ssp_pkg, ssp_in_if
module ssp_front import ssp_pkg::*; #(
  parameter int MAX_PARTICLES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ssp_in_if.sink               in_ch,
  input  logic [SCALE_W-1:0]   phase_scale,
  input  logic [COUNT_W-1:0]   species_a_count,
  input  logic [Q_CNT_W-1:0]   q_count,
  output logic                 push,
  output ssp_work_t            push_item
);

  localparam int IdxW = $clog2(MAX_PARTICLES + 1);
  localparam int CmpW = (IdxW > COUNT_W) ? IdxW : COUNT_W;

  logic [IdxW-1:0] idx_r;
  logic            accept;
  logic            is_a;
  logic [Q_CNT_W:0] occ;

  logic                     s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic signed [DISP_W-1:0] dx_r, dy_r, dz_r;
  logic signed [WAVE_W-1:0] wx_r, wy_r, wz_r;
  logic                     s1_a_r, s1_last_r;

  logic signed [PROD_W-1:0] px_r, py_r, pz_r;
  logic                     s2_a_r, s2_last_r;

  logic signed [DOT_W-1:0]  dot;
  logic signed [DOT_W-1:0]  dot_neg;
  logic [MAG_W-1:0]         mag_r;
  logic                     s3_neg_r, s3_a_r, s3_last_r;

  logic [PPLO_W-1:0]        pp_lo_r;
  logic [PPHI_W-1:0]        pp_hi_r;
  logic                     s4_neg_r, s4_a_r, s4_last_r;

  // every item in flight has a queue slot reserved, so the stages never stall
  assign occ = (Q_CNT_W+1)'(q_count) + (Q_CNT_W+1)'(s1_v_r) + (Q_CNT_W+1)'(s2_v_r)
             + (Q_CNT_W+1)'(s3_v_r) + (Q_CNT_W+1)'(s4_v_r);
  assign in_ch.ready = (occ < (Q_CNT_W+1)'(Q_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_a        = CmpW'(idx_r) < CmpW'(species_a_count);

  assign dot     = DOT_W'(px_r) + DOT_W'(py_r) + DOT_W'(pz_r);
  assign dot_neg = -dot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      if (accept) begin
        if (in_ch.last_particle) begin
          idx_r <= '0;
        end else if (idx_r != IdxW'(MAX_PARTICLES)) begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r      <= in_ch.disp_x;
      dy_r      <= in_ch.disp_y;
      dz_r      <= in_ch.disp_z;
      wx_r      <= in_ch.wave_x;
      wy_r      <= in_ch.wave_y;
      wz_r      <= in_ch.wave_z;
      s1_a_r    <= is_a;
      s1_last_r <= in_ch.last_particle;
    end
    px_r      <= PROD_W'(dx_r) * PROD_W'(wx_r);
    py_r      <= PROD_W'(dy_r) * PROD_W'(wy_r);
    pz_r      <= PROD_W'(dz_r) * PROD_W'(wz_r);
    s2_a_r    <= s1_a_r;
    s2_last_r <= s1_last_r;

    s3_neg_r  <= dot[DOT_W-1];
    mag_r     <= dot[DOT_W-1] ? dot_neg[MAG_W-1:0] : dot[MAG_W-1:0];
    s3_a_r    <= s2_a_r;
    s3_last_r <= s2_last_r;

    pp_lo_r   <= PPLO_W'(mag_r[MAG_LO_W-1:0]) * PPLO_W'(phase_scale);
    pp_hi_r   <= PPHI_W'(mag_r[MAG_W-1:MAG_LO_W]) * PPHI_W'(phase_scale);
    s4_neg_r  <= s3_neg_r;
    s4_a_r    <= s3_a_r;
    s4_last_r <= s3_last_r;
  end

  assign push            = s4_v_r;
  assign push_item.pp_lo = pp_lo_r;
  assign push_item.pp_hi = pp_hi_r;
  assign push_item.neg   = s4_neg_r;
  assign push_item.is_a  = s4_a_r;
  assign push_item.last  = s4_last_r;

endmodule

@@ hdl/ssp_queue.sv @@
// ssp_queue: short fifo of classified work items between front and back
// depends on ssp_pkg
module ssp_queue import ssp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ssp_work_t          push_item,
  input  logic               pop,
  output ssp_work_t          head,
  output logic [Q_CNT_W-1:0] count
);

  ssp_work_t          mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

@@ hdl/ssp_back.sv @@
// ssp_back: modulo 2 pi reduction, iterative cordic, species accumulators and
// the result register; depends on ssp_pkg, ssp_out_if
module ssp_back import ssp_pkg::*; #(
  parameter int CORDIC_STAGES = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_nonempty,
  input  ssp_work_t q_head,
  output logic      pop,
  ssp_out_if.source out_ch
);

  localparam int IterW = $clog2(CORDIC_STAGES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_QEST, ST_QMUL, ST_SUB, ST_CORR, ST_NEG, ST_WRAP, ST_FOLD, ST_ROT,
    ST_ROUND, ST_ACC
  } state_t;

  state_t                  state_r;
  logic [PROD_TOT_W-1:0]   prod_r;
  logic [QUOT_W-1:0]       quot_r;
  logic [RES_W:0]          qm_r;
  logic [RES_W:0]          rem_w_r;
  logic [RES_W-1:0]        rem_r;
  logic                    neg_r, is_a_r, last_r, flip_r;
  logic signed [ANG_W-1:0] x_r, y_r, z_r;
  logic [IterW-1:0]        iter_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r;
  logic signed [SUM_W-1:0] acc_re_a_r, acc_im_a_r, acc_re_b_r, acc_im_b_r;
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_re_a_r, out_im_a_r, out_re_b_r, out_im_b_r;

  logic [PROD_TOT_W-1:0]           prod_nxt;
  logic [QTOP_W+RECIP_W-1:0]       qe_p;
  logic [QUOT_W+M_SPLIT-1:0]       qm_lo_p;
  logic [QUOT_W+RES_W-M_SPLIT-1:0] qm_hi_p;
  logic [RES_W:0]                  qm_nxt;
  logic [RES_W:0]                  rem_sub;
  logic                            emit;
  logic signed [ANG_W-1:0] theta;
  logic signed [ANG_W-1:0] xs, ys, atan_v;
  logic signed [ANG_W-1:0] xv, yv;
  logic signed [ANG_W:0]   x_rnd, y_rnd;
  logic signed [SUM_W-1:0] re_nxt, im_nxt;

  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  a,
    input logic signed [TRIG_W-1:0] b
  );
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
    if (s > SUM_MAX) begin
      return SUM_MAX[SUM_W-1:0];
    end else if (s < SUM_MIN) begin
      return SUM_MIN[SUM_W-1:0];
    end
    return s[SUM_W-1:0];
  endfunction

  assign pop = (state_r == ST_IDLE) && q_nonempty;

  assign prod_nxt = PROD_TOT_W'(q_head.pp_lo) + (PROD_TOT_W'(q_head.pp_hi) << MAG_LO_W);

  // quotient estimate from the top product bits, never above the true quotient
  assign qe_p    = (QTOP_W+RECIP_W)'(prod_r[PROD_TOT_W-1:QTOP_LSB])
                 * (QTOP_W+RECIP_W)'(RECIP_TWO_PI);
  assign qm_lo_p = (QUOT_W+M_SPLIT)'(quot_r)
                 * (QUOT_W+M_SPLIT)'(TWO_PI_Q44[M_SPLIT-1:0]);
  assign qm_hi_p = (QUOT_W+RES_W-M_SPLIT)'(quot_r)
                 * (QUOT_W+RES_W-M_SPLIT)'(TWO_PI_Q44[RES_W-1:M_SPLIT]);
  // remainder before correction is below 2 * (2 pi), so 48 low bits are enough
  assign qm_nxt  = qm_lo_p[RES_W:0] + {qm_hi_p[RES_W-M_SPLIT:0], {M_SPLIT{1'b0}}};
  assign rem_sub = rem_w_r - {1'b0, TWO_PI_Q44};
  assign theta   = ANG_W'(rem_r[RES_W-1:FRAC_DROP]);

  assign xs     = x_r >>> iter_r;
  assign ys     = y_r >>> iter_r;
  assign atan_v = atan_q30(ATAN_IDX_W'(iter_r));

  assign xv    = flip_r ? -x_r : x_r;
  assign yv    = flip_r ? -y_r : y_r;
  assign x_rnd = ((ANG_W+1)'(xv) + (ANG_W+1)'(1 << (FRAC_DROP - 1))) >>> FRAC_DROP;
  assign y_rnd = ((ANG_W+1)'(yv) + (ANG_W+1)'(1 << (FRAC_DROP - 1))) >>> FRAC_DROP;

  assign re_nxt = sat_add(is_a_r ? acc_re_a_r : acc_re_b_r, cos_r);
  assign im_nxt = sat_add(is_a_r ? acc_im_a_r : acc_im_b_r, sin_r);

  assign emit = (state_r == ST_ACC) && last_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc_re_a_r  <= '0;
      acc_im_a_r  <= '0;
      acc_re_b_r  <= '0;
      acc_im_b_r  <= '0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_nonempty) begin
            prod_r  <= prod_nxt;
            neg_r   <= q_head.neg;
            is_a_r  <= q_head.is_a;
            last_r  <= q_head.last;
            state_r <= ST_QEST;
          end
        end
        ST_QEST: begin
          quot_r  <= qe_p[QTOP_W+RECIP_W-1:RECIP_SHIFT];
          state_r <= ST_QMUL;
        end
        ST_QMUL: begin
          qm_r    <= qm_nxt;
          state_r <= ST_SUB;
        end
        ST_SUB: begin
          rem_w_r <= prod_r[RES_W:0] - qm_r;
          state_r <= ST_CORR;
        end
        ST_CORR: begin
          rem_r   <= (rem_w_r >= {1'b0, TWO_PI_Q44}) ? rem_sub[RES_W-1:0]
                                                     : rem_w_r[RES_W-1:0];
          state_r <= ST_NEG;
        end
        ST_NEG: begin
          if (neg_r && (rem_r != '0)) begin
            rem_r <= TWO_PI_Q44 - rem_r;
          end
          state_r <= ST_WRAP;
        end
        ST_WRAP: begin
          z_r     <= (theta > PI_Q30) ? theta - TWO_PI_Q30 : theta;
          state_r <= ST_FOLD;
        end
        ST_FOLD: begin
          // outer half-planes rotate by pi and negate the result
          if (z_r > HALF_PI_Q30) begin
            z_r    <= z_r - PI_Q30;
            flip_r <= 1'b1;
          end else if (z_r < -HALF_PI_Q30) begin
            z_r    <= z_r + PI_Q30;
            flip_r <= 1'b1;
          end else begin
            flip_r <= 1'b0;
          end
          x_r     <= GAIN_Q30;
          y_r     <= '0;
          iter_r  <= '0;
          state_r <= ST_ROT;
        end
        ST_ROT: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - atan_v;
          end else begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + atan_v;
          end
          iter_r <= iter_r + 1'b1;
          if (iter_r == IterW'(CORDIC_STAGES - 1)) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          cos_r   <= x_rnd[TRIG_W-1:0];
          sin_r   <= y_rnd[TRIG_W-1:0];
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (!last_r) begin
            if (is_a_r) begin
              acc_re_a_r <= re_nxt;
              acc_im_a_r <= im_nxt;
            end else begin
              acc_re_b_r <= re_nxt;
              acc_im_b_r <= im_nxt;
            end
            state_r <= ST_IDLE;
          end else if (emit) begin
            out_re_a_r  <= is_a_r ? re_nxt : acc_re_a_r;
            out_im_a_r  <= is_a_r ? im_nxt : acc_im_a_r;
            out_re_b_r  <= is_a_r ? acc_re_b_r : re_nxt;
            out_im_b_r  <= is_a_r ? acc_im_b_r : im_nxt;
            acc_re_a_r  <= '0;
            acc_im_a_r  <= '0;
            acc_re_b_r  <= '0;
            acc_im_b_r  <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.sum_re_a = out_re_a_r;
  assign out_ch.sum_im_a = out_im_a_r;
  assign out_ch.sum_re_b = out_re_b_r;
  assign out_ch.sum_im_b = out_im_b_r;

endmodule

@@ hdl/self_scattering_phase_accumulator_unit.sv @@
// self_scattering_phase_accumulator_unit: top level, configuration registers and
// the front / queue / back split; depends on ssp_pkg, ssp_in_if, ssp_out_if,
// ssp_front, ssp_queue, ssp_back
//
//   port    dir   handshake       carries
//   in_ch   sink  valid / ready   disp_x..z, wave_x..z, last_particle
//   out_ch  src   valid / ready   sum_re_a, sum_im_a, sum_re_b, sum_im_b
//   cfg_*   in    cfg_we          cfg_index, cfg_data (no read-back)
//
// the back end loads an item, reduces it modulo 2 pi by reciprocal multiply,
// gives it its sign, wraps and folds it, runs the cordic iterations, then rounds
// and accumulates it; the front pipeline is registered ahead of the queue
// the front takes items while the 8 entry queue has room, so it keeps accepting
// while the back end works or while a result waits for out_ch.ready
// reset (rst_n low, synchronous) clears the sums, the particle index and the queue
module self_scattering_phase_accumulator_unit import ssp_pkg::*; #(
  parameter int MAX_PARTICLES = 4096,
  parameter int CORDIC_STAGES = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ssp_in_if.sink                in_ch,
  ssp_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SCALE_W-1:0] phase_scale_r;
  logic [COUNT_W-1:0] species_a_count_r;
  logic [Q_CNT_W-1:0] q_count;
  logic               push, pop;
  ssp_work_t          push_item, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_scale_r     <= SCALE_RST;
      species_a_count_r <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_SCALE:     phase_scale_r     <= cfg_data[SCALE_W-1:0];
        REG_SPECIES_A_COUNT: species_a_count_r <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssp_front #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .phase_scale     (phase_scale_r),
    .species_a_count (species_a_count_r),
    .q_count         (q_count),
    .push            (push),
    .push_item       (push_item)
  );

  ssp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (q_head),
    .count     (q_count)
  );

  ssp_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_count != '0),
    .q_head     (q_head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ verif/ssp_sum_checker.sv @@
`timescale 1ns / 1ps
// ssp_sum_checker: watches the particle, sum and register ports of the phase accumulator,
// predicts each emitted sum set and compares it field by field
// depends on ssp_pkg, ssp_in_if and ssp_out_if
module ssp_sum_checker import ssp_pkg::*; #(
  parameter int MAX_PARTICLES = 4096,
  parameter int CORDIC_STAGES = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ssp_in_if                     particles,
  ssp_out_if                    sums,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam logic [46:0] TURN_Q44         = 47'h6487ED5110B5;
  localparam longint      HALF_TURN_Q30    = 64'sh0C90FDAA2;
  localparam longint      TURN_Q30         = 64'sh1921FB544;
  localparam longint      QUARTER_TURN_Q30 = 64'sh06487ED51;
  localparam longint      CORDIC_X0        = 64'sh026DD3B6A;
  localparam longint      SUM_HI           = 64'sh3FFFFFFFF;
  localparam longint      SUM_LO           = -64'sh400000000;

  localparam longint ARCTAN_Q30 [32] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
    'h00000001, 'h00000000
  };

  typedef struct packed {
    logic signed [SUM_W-1:0] re_a;
    logic signed [SUM_W-1:0] im_a;
    logic signed [SUM_W-1:0] re_b;
    logic signed [SUM_W-1:0] im_b;
  } sum_set_t;

  sum_set_t           expected_sums[$];
  logic [SCALE_W-1:0] scale_reg;
  logic [COUNT_W-1:0] split_reg;
  int                 particle_idx;
  longint             acc_re_a, acc_im_a, acc_re_b, acc_im_b;

  // cos and sin of scale * (disp . wave), Q.16
  function automatic void particle_phasor(
    input  logic signed [DISP_W-1:0] dx, dy, dz,
    input  logic signed [WAVE_W-1:0] wx, wy, wz,
    input  logic [SCALE_W-1:0]       scale,
    output longint                   cos_q16,
    output longint                   sin_q16
  );
    longint      dot, angle, x, y, z, x_sh, y_sh;
    logic [79:0] product, rem_wide;
    logic [46:0] rem;
    bit          flip;
    dot = longint'(dx) * longint'(wx) + longint'(dy) * longint'(wy)
        + longint'(dz) * longint'(wz);
    product  = {16'b0, (dot < 0) ? -dot : dot} * {48'b0, scale};
    rem_wide = product % {33'b0, TURN_Q44};
    rem      = rem_wide[46:0];
    if (dot < 0 && rem != 0) rem = TURN_Q44 - rem;
    angle = longint'({17'b0, rem}) >>> 14;
    if (angle > HALF_TURN_Q30) angle = angle - TURN_Q30;
    // fold into the cordic's convergence range, negate afterwards
    flip = 1'b0;
    if (angle > QUARTER_TURN_Q30) begin
      angle = angle - HALF_TURN_Q30;
      flip  = 1'b1;
    end else if (angle < -QUARTER_TURN_Q30) begin
      angle = angle + HALF_TURN_Q30;
      flip  = 1'b1;
    end
    x = CORDIC_X0;
    y = 0;
    z = angle;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      x_sh = x >>> i;
      y_sh = y >>> i;
      if (z >= 0) begin
        x = x - y_sh;
        y = y + x_sh;
        z = z - ARCTAN_Q30[i];
      end else begin
        x = x + y_sh;
        y = y - x_sh;
        z = z + ARCTAN_Q30[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q16 = (x + 64'sd8192) >>> 14;
    sin_q16 = (y + 64'sd8192) >>> 14;
  endfunction

  function automatic longint saturate_sum(input longint a, input longint b);
    longint r;
    r = a + b;
    if (r > SUM_HI) return SUM_HI;
    if (r < SUM_LO) return SUM_LO;
    return r;
  endfunction

  function automatic bit field_ok(input string name, input logic signed [SUM_W-1:0] want,
                                  input logic signed [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : track
    sum_set_t want, got;
    longint   cos_q16, sin_q16;
    bit       ok;
    if (!rst_n) begin
      scale_reg    = SCALE_RST;
      split_reg    = COUNT_RST;
      particle_idx = 0;
      acc_re_a     = 0;
      acc_im_a     = 0;
      acc_re_b     = 0;
      acc_im_b     = 0;
      expected_sums.delete();
      pending <= 0;
    end else begin
      if (sums.valid && sums.ready) begin
        got = {sums.sum_re_a, sums.sum_im_a, sums.sum_re_b, sums.sum_im_b};
        if (expected_sums.size() == 0) begin
          $display("%0t: sum item with none expected, actual %0d %0d %0d %0d", $time,
                   got.re_a, got.im_a, got.re_b, got.im_b);
          fail_count++;
        end else begin
          want = expected_sums.pop_front();
          ok = field_ok("sum_re_a", want.re_a, got.re_a) & field_ok("sum_im_a", want.im_a, got.im_a)
             & field_ok("sum_re_b", want.re_b, got.re_b) & field_ok("sum_im_b", want.im_b, got.im_b);
          if (!ok) fail_count++;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_SCALE:     scale_reg = cfg_data[SCALE_W-1:0];
          REG_SPECIES_A_COUNT: split_reg = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (particles.valid && particles.ready) begin
        particle_phasor(particles.disp_x, particles.disp_y, particles.disp_z,
                        particles.wave_x, particles.wave_y, particles.wave_z,
                        scale_reg, cos_q16, sin_q16);
        if (particle_idx < int'(split_reg)) begin
          acc_re_a = saturate_sum(acc_re_a, cos_q16);
          acc_im_a = saturate_sum(acc_im_a, sin_q16);
        end else begin
          acc_re_b = saturate_sum(acc_re_b, cos_q16);
          acc_im_b = saturate_sum(acc_im_b, sin_q16);
        end
        // index sticks at the particle limit
        if (particle_idx < MAX_PARTICLES) particle_idx++;
        if (particles.last_particle) begin
          want = {acc_re_a[SUM_W-1:0], acc_im_a[SUM_W-1:0],
                  acc_re_b[SUM_W-1:0], acc_im_b[SUM_W-1:0]};
          expected_sums.push_back(want);
          acc_re_a     = 0;
          acc_im_a     = 0;
          acc_re_b     = 0;
          acc_im_b     = 0;
          particle_idx = 0;
        end
      end
      pending <= expected_sums.size();
    end
  end

endmodule

@@ verif/self_scattering_phase_accumulator_unit_test.sv @@
`timescale 1ns / 1ps
// self_scattering_phase_accumulator_unit_test: clock, reset, register writes and paced
// particle / sum traffic around the accumulator; checking sits in ssp_sum_checker
// depends on ssp_pkg, ssp_in_if, ssp_out_if, the accumulator RTL and ssp_sum_checker
module self_scattering_phase_accumulator_unit_test import ssp_pkg::*;;

  localparam int MAX_PARTICLES  = 4096;
  localparam int CORDIC_STAGES  = 20;
  localparam int SETTLE_CYCLES  = (Q_DEPTH + 2) * (CORDIC_STAGES + 10) + 16;
  localparam int STALL_LIMIT    = 4000;
  localparam int SQUEEZE_CYCLES = 600;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [DISP_W-1:0]    DISP_ONE    = 32'h0001_0000;

  typedef struct packed {
    logic [DISP_W-1:0] disp_x;
    logic [DISP_W-1:0] disp_y;
    logic [DISP_W-1:0] disp_z;
    logic [WAVE_W-1:0] wave_x;
    logic [WAVE_W-1:0] wave_y;
    logic [WAVE_W-1:0] wave_z;
    logic              last_particle;
  } particle_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm, squeeze_req, squeeze_done;
  int                    fail_count, pending, stall_cycles;

  ssp_in_if  in_ch ();
  ssp_out_if out_ch ();

  self_scattering_phase_accumulator_unit #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  ssp_sum_checker #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) sum_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .particles (in_ch),
    .sums      (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // cycles without any item moving on either channel
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT - 1) begin
        $display("self_scattering_phase_accumulator_unit regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // receiver pacing, with one long hold-off so the queue fills and input stalls
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        out_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
        squeeze_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic particle_t make_particle(
    input logic [DISP_W-1:0] dx, dy, dz,
    input logic [WAVE_W-1:0] wx, wy, wz,
    input logic              last
  );
    return '{dx, dy, dz, wx, wy, wz, last};
  endfunction

  function automatic logic [DISP_W-1:0] random_disp();
    logic [DISP_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = '0;
      3, 4:    v = DISP_W'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [WAVE_W-1:0] random_wave();
    logic [WAVE_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 10'h1FF;
      1:       v = 10'h200;
      2:       v = '0;
      3, 4:    v = WAVE_W'($urandom_range(0, 8)) - 10'd4;
      default: v = WAVE_W'($urandom());
    endcase
    return v;
  endfunction

  function automatic int sum_length(input bit short_sums);
    if (short_sums) return $urandom_range(1, 4);
    case ($urandom_range(0, 15))
      14:      return $urandom_range(31, 80);
      15:      return 1;
      10, 11, 12, 13: return $urandom_range(9, 30);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  task automatic send_particle(input particle_t p);
    if (!calm && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.disp_x        <= p.disp_x;
    in_ch.disp_y        <= p.disp_y;
    in_ch.disp_z        <= p.disp_z;
    in_ch.wave_x        <= p.wave_x;
    in_ch.wave_y        <= p.wave_y;
    in_ch.wave_z        <= p.wave_z;
    in_ch.last_particle <= p.last_particle;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_sum(input int len);
    particle_t p;
    for (int i = 0; i < len; i++) begin
      p = make_particle(random_disp(), random_disp(), random_disp(),
                        random_wave(), random_wave(), random_wave(), 1'b0);
      p.last_particle = (i == len - 1);
      send_particle(p);
    end
  endtask

  task automatic random_phase(input int n_items, input bit short_sums);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = sum_length(short_sums);
      if (len > left) len = left;
      send_sum(len);
      left -= len;
    end
  endtask

  // every phase ends on a last particle, so the block is idle once nothing is owed
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // count written with junk above its width, plus a write to an unused index
  task automatic configure(input logic [SCALE_W-1:0] scale, input logic [COUNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] data;
    data                = $urandom();
    data[COUNT_W-1:0]   = count;
    write_reg(REG_PHASE_SCALE, scale);
    write_reg(REG_SPECIES_A_COUNT, data);
    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom());
  endtask

  initial begin
    logic [SCALE_W-1:0] scales [7];
    logic [COUNT_W-1:0] counts [7];
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.disp_x        <= '0;
    in_ch.disp_y        <= '0;
    in_ch.disp_z        <= '0;
    in_ch.wave_x        <= '0;
    in_ch.wave_y        <= '0;
    in_ch.wave_z        <= '0;
    in_ch.last_particle <= 1'b0;
    scales = '{32'h0, 32'hFFFF_FFFF, 32'h1000_0000, 32'h1, $urandom(), $urandom(), $urandom()};
    counts = '{13'd0, 13'h1FFF, 13'd5, 13'd1, COUNT_W'($urandom_range(0, 40)), 13'd4096,
               COUNT_W'($urandom_range(0, 40))};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register reset values: box length 1, so one unit of displacement is 2 pi
    send_particle(make_particle('0, '0, '0, '0, '0, '0, 1'b1));
    send_particle(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                10'h1FF, 10'h1FF, 10'h1FF, 1'b1));
    send_particle(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                10'h200, 10'h200, 10'h200, 1'b1));
    send_particle(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                10'h200, 10'h1FF, 10'h200, 1'b0));
    send_particle(make_particle(32'h8000_0000, 32'h7FFF_FFFF, '0, 10'h1FF, 10'h200, '0, 1'b0));
    send_particle(make_particle(32'h1, '0, '0, 10'h1, '0, '0, 1'b1));
    send_particle(make_particle(DISP_ONE, '0, '0, 10'h1, '0, '0, 1'b1));
    send_particle(make_particle(32'h0000_8000, '0, '0, 10'h1, '0, '0, 1'b1));
    send_particle(make_particle(32'hFFFF_8000, '0, '0, 10'h1, '0, '0, 1'b1));
    send_particle(make_particle(32'h0001_8000, '0, '0, 10'h1, '0, '0, 1'b1));
    send_particle(make_particle(32'hFFFE_0000, '0, '0, 10'h1, '0, '0, 1'b1));
    send_particle(make_particle('0, 32'h0000_4000, '0, '0, 10'h1, '0, 1'b1));
    send_particle(make_particle(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                10'h2AA, 10'h155, 10'h2AA, 1'b0));
    send_particle(make_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                10'h155, 10'h2AA, 10'h155, 1'b1));
    send_particle(make_particle(32'h7FFF_FFFF, 32'h8000_0000, DISP_ONE, '0, '0, '0, 1'b1));
    send_particle(make_particle('0, '0, DISP_ONE, '0, '0, 10'h3FF, 1'b1));
    settle();

    for (int k = 0; k < 6; k++) begin
      configure(scales[k], counts[k]);
      if (k == 2) begin
        @(posedge clk);
        squeeze_req = 1'b1;
      end
      random_phase(120, k == 2);
      settle();
    end

    @(posedge clk);
    calm = 1'b1;
    configure(scales[6], counts[6]);
    random_phase(130, 1'b0);
    settle();

    if (fail_count == 0) begin
      $display("self_scattering_phase_accumulator_unit regression: pass");
    end else begin
      $display("self_scattering_phase_accumulator_unit regression: fail");
    end
    $finish;
  end

endmodule
